// File: rtl/ttes_pkg.sv
// Package for the thermal trip event selector: field widths, tdata layout,
// zone accumulator, record and event types, event kind codes.
// No dependencies.
package ttes_pkg;

    localparam int TEMP_W  = 18;
    localparam int HYST_W  = 17;
    localparam int ID_W    = 4;
    localparam int STAMP_W = 48;
    localparam int CPT_W   = TEMP_W + 1;

    // Input tdata layout, lowest bit first
    localparam int S_ZT_LSB    = 0;
    localparam int S_TT_LSB    = S_ZT_LSB + TEMP_W;
    localparam int S_HY_LSB    = S_TT_LSB + TEMP_W;
    localparam int S_ID_LSB    = S_HY_LSB + HYST_W;
    localparam int S_HS_LSB    = S_ID_LSB + ID_W;
    localparam int S_CS_LSB    = S_HS_LSB + STAMP_W;
    localparam int S_RAW_W     = S_CS_LSB + STAMP_W;
    localparam int S_TDATA_W   = ((S_RAW_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 3;
    localparam int S_U_HASTRIP = 0;
    localparam int S_U_ZONEEND = 1;
    localparam int S_U_FIRST   = 2;

    // Output tdata layout, lowest bit first
    localparam int M_ID_LSB  = 0;
    localparam int M_ST_LSB  = M_ID_LSB + ID_W;
    localparam int M_RAW_W   = M_ST_LSB + STAMP_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic EV_HEAT = 1'b0;
    localparam logic EV_COOL = 1'b1;

    typedef struct packed {
        logic                      low_valid;
        logic signed [TEMP_W-1:0]  low_point;
        logic                      heat_valid;
        logic signed [TEMP_W-1:0]  heat_val;
        logic [ID_W-1:0]           heat_id;
        logic [STAMP_W-1:0]        heat_stamp;
        logic                      cool_valid;
        logic signed [CPT_W-1:0]   cool_val;
        logic [ID_W-1:0]           cool_id;
        logic [STAMP_W-1:0]        cool_stamp;
        logic signed [TEMP_W-1:0]  temp;
    } zone_acc_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  zone_temp;
        logic                      has_trip;
        logic signed [TEMP_W-1:0]  trip_temp;
        logic [HYST_W-1:0]         trip_hyst;
        logic [ID_W-1:0]           trip_id;
        logic [STAMP_W-1:0]        heating_stamp;
        logic [STAMP_W-1:0]        cooling_stamp;
        logic                      zone_end;
        logic                      scan_end;
        logic                      first_scan;
    } record_t;

    typedef struct packed {
        logic                event_kind;
        logic [ID_W-1:0]     event_trip;
        logic [STAMP_W-1:0]  event_stamp;
        logic                last_event;
    } event_t;

    typedef struct packed {
        zone_acc_t   cur_next;
        zone_acc_t   best_next;
        logic        best_valid_next;
        logic [1:0]  ev_count;
        event_t      ev0;
        event_t      ev1;
    } step_t;

endpackage

// File: rtl/thermal_trip_event_selector_top.sv
// Top level of the thermal trip event selector: input register, zone
// accumulators, scan-end decision (ttes_step) and result queue (ttes_fifo).
// Depends on ttes_pkg.
//
//  channel | dir | tdata (low bit up)                          | tuser                | tlast
//  --------+-----+---------------------------------------------+----------------------+----------
//  s_      | in  | zone_temp, trip_temp, trip_hyst, trip_id,   | has_trip, zone_end,  | scan_end
//          |     | heating_stamp, cooling_stamp, zero pad      | first_scan           |
//  m_      | out | event_trip, event_stamp, zero pad           | event_kind           | last_event
//
// One trip record is taken per cycle while s_tready is high. A record waits in the
// input register, is folded into the zone accumulators as it leaves, and any
// event is written into the result queue; the first event shows on m_ from the
// queue head once written. A scan that ends in a cooling event on the first scan
// yields two words, which drain one per cycle while m_tready is high through the
// single read port of the queue. Input is held back only while a record waits in
// the input register and the queue lacks room for two words.
// Synchronous active-low reset clears all accumulators and the queue at once.
module thermal_trip_event_selector_top #(
    parameter int FIFO_DEPTH = ttes_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // zone_temp, trip_temp, trip_hyst, trip_id, heating_stamp, cooling_stamp
    input  logic [ttes_pkg::S_TDATA_W-1:0]   s_tdata,
    // has_trip, zone_end, first_scan
    input  logic [ttes_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_trip, event_stamp
    output logic [ttes_pkg::M_TDATA_W-1:0]   m_tdata,
    // event_kind
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast
);

    ttes_pkg::record_t   rec_reg, rec_next;
    logic                in_valid_reg;
    ttes_pkg::zone_acc_t cur_reg, best_reg;
    logic                best_valid_reg;
    ttes_pkg::step_t     step;
    logic                room;
    logic                consume;
    logic [1:0]          push_count;
    logic                head_valid;
    ttes_pkg::event_t    head;

    // Unpack the incoming word
    always_comb begin
        rec_next.zone_temp     = s_tdata[ttes_pkg::S_ZT_LSB +: ttes_pkg::TEMP_W];
        rec_next.trip_temp     = s_tdata[ttes_pkg::S_TT_LSB +: ttes_pkg::TEMP_W];
        rec_next.trip_hyst     = s_tdata[ttes_pkg::S_HY_LSB +: ttes_pkg::HYST_W];
        rec_next.trip_id       = s_tdata[ttes_pkg::S_ID_LSB +: ttes_pkg::ID_W];
        rec_next.heating_stamp = s_tdata[ttes_pkg::S_HS_LSB +: ttes_pkg::STAMP_W];
        rec_next.cooling_stamp = s_tdata[ttes_pkg::S_CS_LSB +: ttes_pkg::STAMP_W];
        rec_next.has_trip      = s_tuser[ttes_pkg::S_U_HASTRIP];
        rec_next.zone_end      = s_tuser[ttes_pkg::S_U_ZONEEND];
        rec_next.first_scan    = s_tuser[ttes_pkg::S_U_FIRST];
        rec_next.scan_end      = s_tlast;
    end

    // Advance the held record once the queue can take a worst-case pair
    assign consume    = in_valid_reg & room;
    assign s_tready   = !in_valid_reg | room;
    assign push_count = consume ? step.ev_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cur_reg        <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (consume) begin
                cur_reg        <= step.cur_next;
                best_reg       <= step.best_next;
                best_valid_reg <= step.best_valid_next;
            end
        end
    end

    ttes_step u_step (
        .rec        (rec_reg),
        .cur        (cur_reg),
        .best       (best_reg),
        .best_valid (best_valid_reg),
        .step       (step)
    );

    ttes_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (step.ev0),
        .push1      (step.ev1),
        .room       (room),
        .pop        (m_tvalid & m_tready),
        .head_valid (head_valid),
        .head       (head)
    );

    // Pack the outgoing word
    always_comb begin
        m_tdata = '0;
        m_tdata[ttes_pkg::M_ID_LSB +: ttes_pkg::ID_W]    = head.event_trip;
        m_tdata[ttes_pkg::M_ST_LSB +: ttes_pkg::STAMP_W] = head.event_stamp;
    end
    assign m_tvalid   = head_valid;
    assign m_tuser[0] = head.event_kind;
    assign m_tlast    = head.last_event;

    // Events only come out of a scan-end record
    a_event_on_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && (step.ev_count != 2'd0)) |-> rec_reg.scan_end)
        else $error("event produced on a record that does not end the scan");

    // A pair is always heating (not last) followed by cooling (last)
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && (step.ev_count == 2'd2)) |->
        ((step.ev0.event_kind == ttes_pkg::EV_HEAT) && !step.ev0.last_event &&
         (step.ev1.event_kind == ttes_pkg::EV_COOL) && step.ev1.last_event))
        else $error("event pair out of order");

    // Scan end returns the best-zone tracking to its reset state
    a_scan_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && rec_reg.scan_end) |=> (!best_valid_reg && !cur_reg.low_valid))
        else $error("zone state not cleared after scan end");

endmodule

// File: rtl/ttes_step.sv
// Per-record update of the zone accumulators and scan-end event decision.
// Purely combinational; depends on ttes_pkg.
module ttes_step (
    input  ttes_pkg::record_t   rec,
    input  ttes_pkg::zone_acc_t cur,
    input  ttes_pkg::zone_acc_t best,
    input  logic                best_valid,
    output ttes_pkg::step_t     step
);

    ttes_pkg::zone_acc_t                 cur_upd;
    ttes_pkg::zone_acc_t                 best_m;
    logic signed [ttes_pkg::CPT_W-1:0]   cool_point;
    logic signed [ttes_pkg::CPT_W-1:0]   ztemp_ext;
    logic                                zone_done;
    logic                                take_zone;
    logic                                pick_cool;
    logic                                any_ev;
    logic [ttes_pkg::ID_W-1:0]           ev_id;
    logic [ttes_pkg::STAMP_W-1:0]        ev_stamp;

    assign cool_point = $signed({rec.trip_temp[ttes_pkg::TEMP_W-1], rec.trip_temp})
                      - $signed({2'b00, rec.trip_hyst});
    assign ztemp_ext  = $signed({rec.zone_temp[ttes_pkg::TEMP_W-1], rec.zone_temp});
    assign zone_done  = rec.zone_end | rec.scan_end;

    // Fold this record into the zone in progress
    always_comb begin
        cur_upd = cur;
        if (rec.has_trip) begin
            if (!cur.low_valid || ($signed(rec.trip_temp) < $signed(cur.low_point))) begin
                cur_upd.low_valid = 1'b1;
                cur_upd.low_point = rec.trip_temp;
            end
            if (($signed(rec.zone_temp) > $signed(rec.trip_temp)) &&
                (!cur.heat_valid || ($signed(cur.heat_val) < $signed(rec.trip_temp)))) begin
                cur_upd.heat_valid = 1'b1;
                cur_upd.heat_val   = rec.trip_temp;
                cur_upd.heat_id    = rec.trip_id;
                cur_upd.heat_stamp = rec.heating_stamp;
            end
            // later equal cooling points replace earlier ones
            if ((ztemp_ext <= cool_point) &&
                (!cur.cool_valid || ($signed(cur.cool_val) >= cool_point))) begin
                cur_upd.cool_valid = 1'b1;
                cur_upd.cool_val   = cool_point;
                cur_upd.cool_id    = rec.trip_id;
                cur_upd.cool_stamp = rec.cooling_stamp;
            end
        end
        if (zone_done) begin
            cur_upd.temp = rec.zone_temp;
        end
    end

    // Strictly hotter zone replaces the best one, so the first zone wins ties
    assign take_zone = !best_valid || ($signed(rec.zone_temp) > $signed(best.temp));

    always_comb begin
        best_m = best;
        if (zone_done && take_zone) begin
            best_m = cur_upd;
        end
    end

    // Scan-end decision on the merged best zone
    always_comb begin
        pick_cool = 1'b0;
        any_ev    = 1'b1;
        if (best_m.heat_valid && best_m.cool_valid) begin
            pick_cool = best_m.cool_stamp > best_m.heat_stamp;
        end else if (best_m.cool_valid) begin
            pick_cool = 1'b1;
        end else if (!best_m.heat_valid) begin
            any_ev = 1'b0;
        end
        ev_id    = pick_cool ? best_m.cool_id    : best_m.heat_id;
        ev_stamp = pick_cool ? best_m.cool_stamp : best_m.heat_stamp;
        // drop a never-stamped event while the zone sits below its lowest trip
        if ((ev_stamp == '0) && best_m.low_valid &&
            ($signed(best_m.temp) < $signed(best_m.low_point))) begin
            any_ev = 1'b0;
        end
    end

    always_comb begin
        step.cur_next        = zone_done ? '0 : cur_upd;
        step.best_next       = rec.scan_end ? '0 : best_m;
        step.best_valid_next = rec.scan_end ? 1'b0 : (best_valid | zone_done);
        step.ev_count        = 2'd0;
        step.ev0.event_kind  = ttes_pkg::EV_HEAT;
        step.ev0.event_trip  = ev_id;
        step.ev0.event_stamp = ev_stamp;
        step.ev0.last_event  = 1'b1;
        step.ev1.event_kind  = ttes_pkg::EV_COOL;
        step.ev1.event_trip  = ev_id;
        step.ev1.event_stamp = ev_stamp;
        step.ev1.last_event  = 1'b1;
        if (rec.scan_end && any_ev) begin
            if (!pick_cool) begin
                step.ev_count = 2'd1;
            end else if (rec.first_scan) begin
                step.ev_count       = 2'd2;
                step.ev0.last_event = 1'b0;
            end else begin
                step.ev_count       = 2'd1;
                step.ev0.event_kind = ttes_pkg::EV_COOL;
            end
        end
    end

endmodule

// File: rtl/ttes_fifo.sv
// Small result queue: takes up to two events per cycle, hands out one.
// Depends on ttes_pkg for the event type.
module ttes_fifo #(
    parameter int DEPTH = ttes_pkg::FIFO_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_count,
    input  ttes_pkg::event_t push0,
    input  ttes_pkg::event_t push1,
    output logic             room,
    input  logic             pop,
    output logic             head_valid,
    output ttes_pkg::event_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttes_pkg::event_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr1, wr2;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr1 = ptr_inc(wr_ptr_reg);
    assign wr2 = ptr_inc(wr1);

    always_comb begin
        case (push_count)
            2'd1:    wr_ptr_next = wr1;
            2'd2:    wr_ptr_next = wr2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    assign room       = count_reg <= CNT_W'(DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[wr1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: dv/tb_thermal_trip_event_selector_top.sv
// Self-checking testbench for thermal_trip_event_selector_top: directed trip scans
// followed by random scans, with every event word compared against an in-bench predictor.
// Depends on ttes_pkg and the RTL top level only.
module tb_thermal_trip_event_selector_top;

    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam logic [ttes_pkg::STAMP_W-1:0] STAMP_MAX = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

    // Running reduction of one zone; temperatures are kept wide so compares stay exact.
    typedef struct packed {
        bit                            low_ok;
        longint                        low_pt;
        bit                            heat_ok;
        longint                        heat_pt;
        logic [ttes_pkg::ID_W-1:0]     heat_id;
        logic [ttes_pkg::STAMP_W-1:0]  heat_ts;
        bit                            cool_ok;
        longint                        cool_pt;
        logic [ttes_pkg::ID_W-1:0]     cool_id;
        logic [ttes_pkg::STAMP_W-1:0]  cool_ts;
        longint                        temp;
    } zone_run_t;

    // One directed row: a trip record and, where obvious, its events typed in.
    typedef struct {
        ttes_pkg::record_t rec;
        bit                typed;
        int                n;
        ttes_pkg::event_t  e0;
        ttes_pkg::event_t  e1;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ttes_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [ttes_pkg::S_TUSER_W-1:0]   s_tuser  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ttes_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [0:0]                       m_tuser;
    logic                             m_tlast;

    zone_run_t         cur_run;
    zone_run_t         best_run;
    bit                best_ok;
    ttes_pkg::event_t  pending_events[$];
    stim_row_t         dir_tab[$];

    int n_items;
    int n_scans;
    int n_silent;
    int n_pairs;
    int n_checked;
    int n_cool_words;
    int mismatches;
    int burst_left;
    int idle_cycles;
    int ready_left;
    int ready_tick;
    rx_mode_t ready_mode;

    thermal_trip_event_selector_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic ttes_pkg::event_t make_event(logic kind,
                                                    logic [ttes_pkg::ID_W-1:0] id,
                                                    logic [ttes_pkg::STAMP_W-1:0] ts,
                                                    logic last);
        ttes_pkg::event_t e;
        e.event_kind  = kind;
        e.event_trip  = id;
        e.event_stamp = ts;
        e.last_event  = last;
        return e;
    endfunction

    function automatic ttes_pkg::record_t mk(int zt, bit ht, int tt, int hy, int id,
                                             logic [ttes_pkg::STAMP_W-1:0] hs,
                                             logic [ttes_pkg::STAMP_W-1:0] cs,
                                             bit ze, bit se, bit fs);
        ttes_pkg::record_t r;
        r.zone_temp     = zt[ttes_pkg::TEMP_W-1:0];
        r.has_trip      = ht;
        r.trip_temp     = tt[ttes_pkg::TEMP_W-1:0];
        r.trip_hyst     = hy[ttes_pkg::HYST_W-1:0];
        r.trip_id       = id[ttes_pkg::ID_W-1:0];
        r.heating_stamp = hs;
        r.cooling_stamp = cs;
        r.zone_end      = ze;
        r.scan_end      = se;
        r.first_scan    = fs;
        return r;
    endfunction

    function automatic void add_row(ttes_pkg::record_t r, bit typed, int n,
                                    ttes_pkg::event_t e0, ttes_pkg::event_t e1);
        stim_row_t row;
        row.rec   = r;
        row.typed = typed;
        row.n     = n;
        row.e0    = e0;
        row.e1    = e1;
        dir_tab.push_back(row);
    endfunction

    // Temperature near a center, or anywhere in the 18-bit range for wide scans.
    function automatic logic signed [ttes_pkg::TEMP_W-1:0] rand_temp(int center, int spread,
                                                                    bit wide);
        logic [31:0] w;
        int v;
        w = $urandom;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        return wide ? w[ttes_pkg::TEMP_W-1:0] : v[ttes_pkg::TEMP_W-1:0];
    endfunction

    // Zero stamps, small colliding stamps and full-width stamps.
    function automatic logic [ttes_pkg::STAMP_W-1:0] pick_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: begin
                return '0;
            end
            1, 2: begin
                return ttes_pkg::STAMP_W'($urandom_range(1, 8));
            end
            default: begin
                return w[ttes_pkg::STAMP_W-1:0];
            end
        endcase
    endfunction

    // Fold one accepted record into the zone and scan state; return the events it causes.
    function automatic int fold_record(input ttes_pkg::record_t r,
                                       output ttes_pkg::event_t ev0,
                                       output ttes_pkg::event_t ev1);
        longint zt;
        longint tt;
        longint cp;
        bit take_cool;
        bit emit;
        logic [ttes_pkg::ID_W-1:0] tid;
        logic [ttes_pkg::STAMP_W-1:0] ts;
        int n;
        n   = 0;
        ev0 = '0;
        ev1 = '0;
        zt  = $signed(r.zone_temp);
        tt  = $signed(r.trip_temp);
        cp  = tt - longint'(r.trip_hyst);
        if (r.has_trip) begin
            if (!cur_run.low_ok || tt < cur_run.low_pt) begin
                cur_run.low_ok = 1'b1;
                cur_run.low_pt = tt;
            end
            // strict compare: the earliest of equal heating trips stays
            if (zt > tt && (!cur_run.heat_ok || cur_run.heat_pt < tt)) begin
                cur_run.heat_ok = 1'b1;
                cur_run.heat_pt = tt;
                cur_run.heat_id = r.trip_id;
                cur_run.heat_ts = r.heating_stamp;
            end
            // non-strict compare: the latest of equal cooling points takes over
            if (zt <= cp && (!cur_run.cool_ok || cur_run.cool_pt >= cp)) begin
                cur_run.cool_ok = 1'b1;
                cur_run.cool_pt = cp;
                cur_run.cool_id = r.trip_id;
                cur_run.cool_ts = r.cooling_stamp;
            end
        end
        if (r.zone_end || r.scan_end) begin
            cur_run.temp = zt;
            if (!best_ok || cur_run.temp > best_run.temp) begin
                best_run = cur_run;
                best_ok  = 1'b1;
            end
            cur_run = '0;
        end
        if (r.scan_end) begin
            emit      = best_run.heat_ok || best_run.cool_ok;
            take_cool = best_run.cool_ok &&
                        (!best_run.heat_ok || best_run.cool_ts > best_run.heat_ts);
            tid = take_cool ? best_run.cool_id : best_run.heat_id;
            ts  = take_cool ? best_run.cool_ts : best_run.heat_ts;
            // a never-crossed stamp on a zone still below its lowest trip says nothing
            if (emit && ts == '0 && best_run.low_ok && best_run.temp < best_run.low_pt)
                emit = 1'b0;
            if (!emit) begin
                n_silent++;
            end else if (!take_cool) begin
                ev0 = make_event(ttes_pkg::EV_HEAT, tid, ts, 1'b1);
                n   = 1;
            end else if (r.first_scan) begin
                ev0 = make_event(ttes_pkg::EV_HEAT, tid, ts, 1'b0);
                ev1 = make_event(ttes_pkg::EV_COOL, tid, ts, 1'b1);
                n   = 2;
                n_pairs++;
            end else begin
                ev0 = make_event(ttes_pkg::EV_COOL, tid, ts, 1'b1);
                n   = 1;
            end
            n_scans++;
            best_run = '0;
            best_ok  = 1'b0;
        end
        return n;
    endfunction

    // Offer one record on s_, idling between bursts; predict its events once it is taken.
    task automatic send_record(ttes_pkg::record_t r, bit typed, int n_typed,
                               ttes_pkg::event_t t0, ttes_pkg::event_t t1);
        ttes_pkg::event_t p0;
        ttes_pkg::event_t p1;
        logic [ttes_pkg::S_TDATA_W-1:0] d;
        logic [ttes_pkg::S_TUSER_W-1:0] u;
        int n;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                // drop valid and scramble the bus so idle words must be ignored
                s_tvalid <= 1'b0;
                s_tdata  <= ~s_tdata;
                s_tuser  <= ~s_tuser;
                s_tlast  <= ~s_tlast;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        d = '0;
        d[ttes_pkg::S_ZT_LSB +: ttes_pkg::TEMP_W]  = r.zone_temp;
        d[ttes_pkg::S_TT_LSB +: ttes_pkg::TEMP_W]  = r.trip_temp;
        d[ttes_pkg::S_HY_LSB +: ttes_pkg::HYST_W]  = r.trip_hyst;
        d[ttes_pkg::S_ID_LSB +: ttes_pkg::ID_W]    = r.trip_id;
        d[ttes_pkg::S_HS_LSB +: ttes_pkg::STAMP_W] = r.heating_stamp;
        d[ttes_pkg::S_CS_LSB +: ttes_pkg::STAMP_W] = r.cooling_stamp;
        u = '0;
        u[ttes_pkg::S_U_HASTRIP] = r.has_trip;
        u[ttes_pkg::S_U_ZONEEND] = r.zone_end;
        u[ttes_pkg::S_U_FIRST]   = r.first_scan;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= u;
        s_tlast  <= r.scan_end;
        // hold the word until the edge where s_tready was high
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = fold_record(r, p0, p1);
        n_items++;
        if (typed) begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0) pending_events.push_back(p0);
        if (n > 1) pending_events.push_back(p1);
    endtask

    function automatic void note_mismatch(string what, ttes_pkg::event_t want,
                                          ttes_pkg::event_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"mismatch %0d (%s): want kind %0d trip %0d stamp %0h last %0d, ",
                      "got kind %0d trip %0d stamp %0h last %0d"},
                     mismatches, what, want.event_kind, want.event_trip, want.event_stamp,
                     want.last_event, got.event_kind, got.event_trip, got.event_stamp,
                     got.last_event);
    endfunction

    // Receiver: switch among random stall patterns, including fully open stretches.
    always @(posedge aclk) begin : drain_pattern
        if (ready_left == 0) begin
            ready_mode = rx_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        ready_tick++;
        case (ready_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= $urandom_range(0, 1);
            end
            RX_SPARSE: begin
                m_tready <= (ready_tick % 5 == 0);
            end
            default: begin
                m_tready <= (ready_tick % 8 < 5);
            end
        endcase
    end

    // Compare every event word taken on m_ against the oldest expectation.
    always @(posedge aclk) begin : check_events
        ttes_pkg::event_t got;
        ttes_pkg::event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.event_kind  = m_tuser[0];
            got.event_trip  = m_tdata[ttes_pkg::M_ID_LSB +: ttes_pkg::ID_W];
            got.event_stamp = m_tdata[ttes_pkg::M_ST_LSB +: ttes_pkg::STAMP_W];
            got.last_event  = m_tlast;
            n_checked++;
            if (got.event_kind == ttes_pkg::EV_COOL) n_cool_words++;
            if (pending_events.size() == 0) begin
                note_mismatch("no event expected", '0, got);
            end else begin
                want = pending_events.pop_front();
                if (got.event_kind  !== want.event_kind  ||
                    got.event_trip  !== want.event_trip  ||
                    got.event_stamp !== want.event_stamp ||
                    got.last_event  !== want.last_event)
                    note_mismatch("wrong field", want, got);
            end
        end
    end

    // Abort when neither channel moves a word for too long.
    always @(posedge aclk) begin : idle_watch
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d events still due",
                     idle_cycles, pending_events.size());
            $display("tb_thermal_trip_event_selector_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        ttes_pkg::record_t r;
        logic [31:0] w;
        logic [31:0] h;
        logic signed [ttes_pkg::TEMP_W-1:0] zt;
        logic signed [ttes_pkg::TEMP_W-1:0] prev_tt;
        logic [ttes_pkg::HYST_W-1:0] prev_hy;
        int zones;
        int nrec;
        int base;
        bit wide;
        bit fs;
        bit last_rec;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-record scans with obvious outcomes.
        add_row(mk(131071, 1, -131072, 0, 15, STAMP_MAX, '0, 1, 1, 0), 1, 1,
                make_event(ttes_pkg::EV_HEAT, 4'd15, STAMP_MAX, 1'b1), '0);
        add_row(mk(-131072, 1, 131071, 131071, 0, '0, STAMP_MAX, 1, 1, 1), 1, 2,
                make_event(ttes_pkg::EV_HEAT, 4'd0, STAMP_MAX, 1'b0),
                make_event(ttes_pkg::EV_COOL, 4'd0, STAMP_MAX, 1'b1));
        add_row(mk(-131072, 1, 131071, 131071, 9, '0, STAMP_MAX, 1, 1, 0), 1, 1,
                make_event(ttes_pkg::EV_COOL, 4'd9, STAMP_MAX, 1'b1), '0);
        // record without trip: trip fields must be ignored
        add_row(mk(-131072, 0, 131071, 131071, 15, STAMP_MAX, STAMP_MAX, 1, 1, 1), 1, 0,
                '0, '0);
        // nothing crossed
        add_row(mk(75, 1, 100, 50, 3, 48'd7, 48'd7, 1, 1, 0), 1, 0, '0, '0);
        // zero stamp and zone below its lowest trip: suppressed
        add_row(mk(-10, 1, 0, 0, 4, '0, '0, 1, 1, 1), 1, 0, '0, '0);
        // zero stamp but zone not below lowest trip: still reported
        add_row(mk(10, 1, 0, 0, 5, '0, '0, 1, 1, 0), 1, 1,
                make_event(ttes_pkg::EV_HEAT, 4'd5, '0, 1'b1), '0);
        add_row(mk(0, 1, 0, 0, 6, '0, '0, 1, 1, 1), 1, 2,
                make_event(ttes_pkg::EV_HEAT, 4'd6, '0, 1'b0),
                make_event(ttes_pkg::EV_COOL, 4'd6, '0, 1'b1));
        // equal heating trips keep the earliest; equal stamps favor heating
        add_row(mk(200, 1, 100, 0, 1, 48'd5, 48'd9, 0, 0, 0), 0, 0, '0, '0);
        add_row(mk(200, 1, 100, 0, 2, 48'd6, 48'd9, 0, 0, 0), 0, 0, '0, '0);
        add_row(mk(200, 1, 500, 100, 3, 48'd1, 48'd5, 1, 1, 0), 0, 0, '0, '0);
        // equal cooling points take the latest; tied zones keep the first;
        // scan end without zone end
        add_row(mk(-50, 1, 0, 10, 7, 48'd3, 48'd20, 0, 0, 0), 0, 0, '0, '0);
        add_row(mk(-50, 1, 5, 15, 8, 48'd3, 48'd30, 1, 0, 0), 0, 0, '0, '0);
        add_row(mk(-50, 0, 0, 0, 0, '0, '0, 0, 1, 1), 0, 0, '0, '0);
        // per-record zone temperature for compares, last one for the zone
        add_row(mk(0, 1, -100, 0, 10, 48'd40, '0, 1, 0, 0), 0, 0, '0, '0);
        add_row(mk(300, 1, 250, 0, 11, '0, '0, 0, 0, 0), 0, 0, '0, '0);
        add_row(mk(20, 1, 500, 0, 12, '0, '0, 1, 1, 0), 0, 0, '0, '0);
        // only zones without trips
        add_row(mk(131071, 0, 0, 0, 0, '0, '0, 1, 0, 0), 0, 0, '0, '0);
        add_row(mk(-131072, 0, 0, 0, 0, '0, '0, 1, 1, 1), 0, 0, '0, '0);

        foreach (dir_tab[i])
            send_record(dir_tab[i].rec, dir_tab[i].typed, dir_tab[i].n,
                        dir_tab[i].e0, dir_tab[i].e1);

        // Random well-formed scans: clustered temperatures so crossings and ties are common,
        // with an occasional wide scan that exercises every bit.
        prev_tt = '0;
        prev_hy = '0;
        while (n_items < RANDOM_ITEMS + dir_tab.size()) begin
            wide  = ($urandom_range(0, 9) == 0);
            zones = $urandom_range(1, 4);
            fs    = ($urandom_range(0, 2) == 0);
            base  = int'($urandom_range(0, 800)) - 400;
            zt    = rand_temp(base, 40, wide);
            for (int z = 0; z < zones; z++) begin
                // keep the previous zone temperature now and then to tie zones
                if (z != 0 && $urandom_range(0, 3) != 0)
                    zt = rand_temp(base, 40, wide);
                nrec = $urandom_range(1, 5);
                for (int k = 0; k < nrec; k++) begin
                    last_rec    = (k == nrec - 1);
                    r.zone_temp = (!last_rec && $urandom_range(0, 4) == 0)
                                  ? rand_temp(base, 60, wide) : zt;
                    r.has_trip  = ($urandom_range(0, 6) != 0);
                    w = $urandom;
                    h = $urandom_range(0, 50);
                    if (k != 0 && $urandom_range(0, 4) == 0) begin
                        r.trip_temp = prev_tt;
                        r.trip_hyst = prev_hy;
                    end else begin
                        r.trip_temp = rand_temp(zt, 60, wide);
                        r.trip_hyst = (wide || $urandom_range(0, 7) == 0)
                                      ? w[ttes_pkg::HYST_W-1:0] : h[ttes_pkg::HYST_W-1:0];
                    end
                    prev_tt = r.trip_temp;
                    prev_hy = r.trip_hyst;
                    w = $urandom;
                    r.trip_id       = w[ttes_pkg::ID_W-1:0];
                    r.heating_stamp = pick_stamp();
                    r.cooling_stamp = pick_stamp();
                    r.scan_end      = last_rec && (z == zones - 1);
                    r.zone_end      = last_rec && !(r.scan_end && $urandom_range(0, 3) == 0);
                    r.first_scan    = r.scan_end ? fs : bit'($urandom_range(0, 1));
                    send_record(r, 0, 0, '0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain: the watchdog bounds this wait, then allow for stray late words.
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d trip records in %0d scans: %0d event words checked, %0d cooling",
                 n_items, n_scans, n_checked, n_cool_words);
        $display("%0d scans gave a heating/cooling pair, %0d were silent, %0d mismatches",
                 n_pairs, n_silent, mismatches);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("tb_thermal_trip_event_selector_top OK");
        end else begin
            $display("tb_thermal_trip_event_selector_top NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ttes_pkg.sv
rtl/ttes_step.sv
rtl/ttes_fifo.sv
rtl/thermal_trip_event_selector_top.sv
dv/tb_thermal_trip_event_selector_top.sv
